// ===== src/script_token_lexer_assert.svh =====
// Assertion macros for the script token lexer.
// Used by script_token_lexer.sv; expects clk and rst in the including scope.
`ifndef SCRIPT_TOKEN_LEXER_ASSERT_SVH
`define SCRIPT_TOKEN_LEXER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define STL_CHECK_NOW(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("script_token_lexer: check failed");

// Next-cycle implication, checked outside reset.
`define STL_CHECK_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("script_token_lexer: check failed");

`endif

// ===== src/stl_pkg.sv =====
// Shared types and constants for the script token lexer.
// Used by stl_step.sv and script_token_lexer.sv; no dependencies.
package stl_pkg;

  localparam int RES_MAX = 3;

  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_COMMENT,
    MODE_NAME,
    MODE_INT,
    MODE_INTDOT,
    MODE_FLOAT,
    MODE_SYMBOL,
    MODE_STRING
  } lex_mode_t;

  localparam logic [4:0] KIND_END        = 5'd0;
  localparam logic [4:0] KIND_NAME       = 5'd1;
  localparam logic [4:0] KIND_NAME_COLON = 5'd2;
  localparam logic [4:0] KIND_INT        = 5'd3;
  localparam logic [4:0] KIND_FLOAT      = 5'd4;
  localparam logic [4:0] KIND_LBRACE     = 5'd5;
  localparam logic [4:0] KIND_RBRACE     = 5'd6;
  localparam logic [4:0] KIND_LPAREN     = 5'd7;
  localparam logic [4:0] KIND_RPAREN     = 5'd8;
  localparam logic [4:0] KIND_PLUS       = 5'd9;
  localparam logic [4:0] KIND_MINUS      = 5'd10;
  localparam logic [4:0] KIND_STAR       = 5'd11;
  localparam logic [4:0] KIND_SLASH      = 5'd12;
  localparam logic [4:0] KIND_COMMA      = 5'd13;
  localparam logic [4:0] KIND_SYMBOL     = 5'd14;
  localparam logic [4:0] KIND_STRING     = 5'd15;
  localparam logic [4:0] KIND_CLOSING    = 5'd16;
  localparam logic [4:0] KIND_UNKNOWN    = 5'd17;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef struct packed {
    logic [7:0] ch;
    logic       at_end;
  } chr_t;

  typedef struct packed {
    logic        is_text_byte;
    logic [7:0]  text_byte;
    logic [4:0]  token_kind;
    logic [63:0] int_value;
    logic        last_of_run;
  } tok_t;

  // Everything one character produces: its results and the lexer state after it.
  typedef struct packed {
    tok_t [RES_MAX-1:0] res;
    logic [1:0]         cnt;
    lex_mode_t          mode;
    logic               esc;
    logic [63:0]        acc;
  } step_t;

endpackage

// ===== src/script_token_lexer.sv =====
// Top level of the script token lexer: input register, lexer state and result buffer.
// Depends on stl_pkg, stl_step and script_token_lexer_assert.svh.
//
//   channel | direction | handshake            | payload
//   chr     | in        | chr_valid, chr_stall | stl_pkg::chr_t (ch, at_end)
//   tok     | out       | tok_valid, tok_stall | stl_pkg::tok_t (one result)
//
// One character is taken per cycle while chr_stall is low; it is lexed in the cycle after it is taken,
// and its zero to three results load the result buffer when it leaves the character stage.
// The buffer sends one result per cycle while tok_stall is low, and a character with results
// waits in the character stage until the buffer is free; characters with no result pass without waiting.
// Reset returns the lexer to idle between tokens and empties both stages.
// A stall on tok holds the current result and, once the character stage holds a character
// with results, raises chr_stall in the same cycle.
`include "script_token_lexer_assert.svh"

module script_token_lexer (
  input  logic           clk,
  input  logic           rst,
  input  logic           chr_valid,
  output logic           chr_stall,
  input  stl_pkg::chr_t  chr,
  output logic           tok_valid,
  input  logic           tok_stall,
  output stl_pkg::tok_t  tok
);

  logic                                 a_valid;
  stl_pkg::chr_t                        a_item;
  stl_pkg::lex_mode_t                   mode;
  logic                                 esc;
  logic [63:0]                          acc;
  stl_pkg::tok_t [stl_pkg::RES_MAX-1:0] b_res;
  logic [1:0]                           b_cnt;
  logic [1:0]                           b_idx;

  stl_pkg::step_t step;
  logic           b_last;
  logic           b_free;
  logic           out_take;
  logic           a_move;
  logic           in_take;

  stl_step u_step (
    .chr  (a_item),
    .mode (mode),
    .esc  (esc),
    .acc  (acc),
    .step (step)
  );

  assign tok_valid = (b_cnt != 2'd0);
  assign tok       = b_res[b_idx];
  assign out_take  = tok_valid && !tok_stall;
  assign b_last    = (b_idx == (b_cnt - 2'd1));
  assign b_free    = (b_cnt == 2'd0) || (out_take && b_last);
  // A character without results never needs the buffer.
  assign a_move    = a_valid && (b_free || (step.cnt == 2'd0));
  assign chr_stall = a_valid && !a_move;
  assign in_take   = chr_valid && !chr_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      mode    <= stl_pkg::MODE_IDLE;
      esc     <= 1'b0;
      acc     <= '0;
      b_cnt   <= 2'd0;
      b_idx   <= 2'd0;
    end else begin
      if (in_take) begin
        a_valid <= 1'b1;
      end else if (a_move) begin
        a_valid <= 1'b0;
      end
      if (a_move) begin
        mode <= step.mode;
        esc  <= step.esc;
        acc  <= step.acc;
      end
      if (a_move && (step.cnt != 2'd0)) begin
        b_cnt <= step.cnt;
        b_idx <= 2'd0;
      end else if (out_take) begin
        if (b_last) begin
          b_cnt <= 2'd0;
          b_idx <= 2'd0;
        end else begin
          b_idx <= b_idx + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      a_item <= chr;
    end
    if (a_move && (step.cnt != 2'd0)) begin
      b_res <= step.res;
    end
  end

  `STL_CHECK_NOW(a_idx_in_range, b_cnt != 2'd0, b_idx < b_cnt)
  `STL_CHECK_NOW(a_last_matches_idx, tok_valid, tok.last_of_run == b_last)
  `STL_CHECK_NOW(a_esc_only_in_string, esc, mode == stl_pkg::MODE_STRING)
  `STL_CHECK_NEXT(a_end_clears_state, a_move && (a_item.at_end || a_item.ch == stl_pkg::CH_NUL), mode == stl_pkg::MODE_IDLE && acc == 64'd0 && !esc)

endmodule

// ===== src/stl_step.sv =====
// Combinational lexer step: one character against the current lexer state.
// Depends on stl_pkg for the mode enum, token kinds and result structs.
module stl_step (
  input  stl_pkg::chr_t      chr,
  input  stl_pkg::lex_mode_t mode,
  input  logic               esc,
  input  logic [63:0]        acc,
  output stl_pkg::step_t     step
);

  function automatic logic is_digit(logic [7:0] c);
    return (c >= stl_pkg::CH_ZERO) && (c <= stl_pkg::CH_NINE);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= stl_pkg::CH_LOWER_A) && (c <= stl_pkg::CH_LOWER_Z)) ||
           ((c >= stl_pkg::CH_UPPER_A) && (c <= stl_pkg::CH_UPPER_Z));
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == stl_pkg::CH_SPACE) || ((c >= stl_pkg::CH_TAB) && (c <= stl_pkg::CH_CR));
  endfunction

  function automatic logic is_close(logic [7:0] c);
    return (c == stl_pkg::CH_RBRACE) || (c == stl_pkg::CH_RPAREN) ||
           (c == stl_pkg::CH_RBRACK) || (c == stl_pkg::CH_SEMI) || (c == stl_pkg::CH_LF);
  endfunction

  function automatic stl_pkg::tok_t mk_text(logic [7:0] b);
    stl_pkg::tok_t t;
    t = '0;
    t.is_text_byte = 1'b1;
    t.text_byte    = b;
    return t;
  endfunction

  function automatic stl_pkg::tok_t mk_done(logic [4:0] kind, logic [63:0] val);
    stl_pkg::tok_t t;
    t = '0;
    t.token_kind = kind;
    t.int_value  = val;
    return t;
  endfunction

  logic [7:0]                  c;
  logic                        is_end;
  logic                        is_sym;
  logic [63:0]                 acc_x10;
  stl_pkg::lex_mode_t          m;
  logic                        e;
  logic [63:0]                 a;
  stl_pkg::tok_t [stl_pkg::RES_MAX-1:0] r;
  logic [1:0]                  n;
  logic                        redo;
  logic                        start;

  assign c       = chr.ch;
  assign is_end  = chr.at_end || (chr.ch == stl_pkg::CH_NUL);
  assign is_sym  = !(is_space(chr.ch) || is_close(chr.ch));
  assign acc_x10 = (acc << 3) + (acc << 1) + {60'd0, chr.ch[3:0]};

  always_comb begin
    m     = mode;
    e     = esc;
    a     = acc;
    r     = '0;
    n     = 2'd0;
    redo  = 1'b0;
    start = 1'b0;

    if (is_end) begin
      // Flush the open token, a string included, then the end marker; comments just stop.
      case (mode)
        stl_pkg::MODE_NAME: begin
          r[n] = mk_done(stl_pkg::KIND_NAME, '0);
          n = n + 2'd1;
        end
        stl_pkg::MODE_INT: begin
          r[n] = mk_done(stl_pkg::KIND_INT, acc);
          n = n + 2'd1;
        end
        stl_pkg::MODE_INTDOT: begin
          r[n] = mk_done(stl_pkg::KIND_INT, acc);
          n = n + 2'd1;
          r[n] = mk_done(stl_pkg::KIND_SYMBOL, '0);
          n = n + 2'd1;
        end
        stl_pkg::MODE_FLOAT: begin
          r[n] = mk_done(stl_pkg::KIND_FLOAT, acc);
          n = n + 2'd1;
        end
        stl_pkg::MODE_SYMBOL: begin
          r[n] = mk_done(stl_pkg::KIND_SYMBOL, '0);
          n = n + 2'd1;
        end
        stl_pkg::MODE_STRING: begin
          r[n] = mk_done(stl_pkg::KIND_STRING, '0);
          n = n + 2'd1;
        end
        default: begin
        end
      endcase
      r[n] = mk_done(stl_pkg::KIND_END, '0);
      n = n + 2'd1;
      m = stl_pkg::MODE_IDLE;
      e = 1'b0;
      a = '0;
    end else begin
      // First pass in the current mode.
      case (mode)
        stl_pkg::MODE_COMMENT: begin
          if (c == stl_pkg::CH_LF) begin
            m = stl_pkg::MODE_IDLE;
          end
        end
        stl_pkg::MODE_NAME: begin
          if (is_digit(c) || is_alpha(c)) begin
            r[n] = mk_text(c);
            n = n + 2'd1;
          end else if (c == stl_pkg::CH_COLON) begin
            m = stl_pkg::MODE_IDLE;
            r[n] = mk_text(c);
            n = n + 2'd1;
            r[n] = mk_done(stl_pkg::KIND_NAME_COLON, '0);
            n = n + 2'd1;
          end else begin
            m = stl_pkg::MODE_IDLE;
            r[n] = mk_done(stl_pkg::KIND_NAME, '0);
            n = n + 2'd1;
            redo = 1'b1;
          end
        end
        stl_pkg::MODE_INT: begin
          if (is_digit(c)) begin
            a = acc_x10;
            r[n] = mk_text(c);
            n = n + 2'd1;
          end else if (c == stl_pkg::CH_DOT) begin
            m = stl_pkg::MODE_INTDOT;
          end else begin
            m = stl_pkg::MODE_IDLE;
            r[n] = mk_done(stl_pkg::KIND_INT, acc);
            n = n + 2'd1;
            redo = 1'b1;
          end
        end
        stl_pkg::MODE_INTDOT: begin
          if (is_digit(c)) begin
            m = stl_pkg::MODE_FLOAT;
            r[n] = mk_text(stl_pkg::CH_DOT);
            n = n + 2'd1;
            r[n] = mk_text(c);
            n = n + 2'd1;
          end else begin
            // The dot did not start a fraction: it opens a symbol instead.
            m = stl_pkg::MODE_SYMBOL;
            r[n] = mk_done(stl_pkg::KIND_INT, acc);
            n = n + 2'd1;
            redo = 1'b1;
          end
        end
        stl_pkg::MODE_FLOAT: begin
          if (is_digit(c)) begin
            r[n] = mk_text(c);
            n = n + 2'd1;
          end else begin
            m = stl_pkg::MODE_IDLE;
            r[n] = mk_done(stl_pkg::KIND_FLOAT, acc);
            n = n + 2'd1;
            redo = 1'b1;
          end
        end
        stl_pkg::MODE_SYMBOL: begin
          if (is_sym) begin
            r[n] = mk_text(c);
            n = n + 2'd1;
          end else begin
            m = stl_pkg::MODE_IDLE;
            r[n] = mk_done(stl_pkg::KIND_SYMBOL, '0);
            n = n + 2'd1;
            redo = 1'b1;
          end
        end
        stl_pkg::MODE_STRING: begin
          if (esc) begin
            e = 1'b0;
            r[n] = mk_text(c);
            n = n + 2'd1;
          end else if (c == stl_pkg::CH_QUOTE) begin
            m = stl_pkg::MODE_IDLE;
            r[n] = mk_done(stl_pkg::KIND_STRING, '0);
            n = n + 2'd1;
          end else begin
            r[n] = mk_text(c);
            n = n + 2'd1;
            e = (c == stl_pkg::CH_BSLASH);
          end
        end
        default: begin
          start = 1'b1;
        end
      endcase

      // Second pass: the character re-enters a symbol opened by a trailing dot.
      if (redo && (m == stl_pkg::MODE_SYMBOL)) begin
        if (is_sym) begin
          r[n] = mk_text(c);
          n = n + 2'd1;
          redo = 1'b0;
        end else begin
          m = stl_pkg::MODE_IDLE;
          r[n] = mk_done(stl_pkg::KIND_SYMBOL, '0);
          n = n + 2'd1;
        end
      end

      // Last pass: the character starts a new token from idle.
      if (start || (redo && (m == stl_pkg::MODE_IDLE))) begin
        m = stl_pkg::MODE_IDLE;
        if (is_space(c)) begin
        end else if (c == stl_pkg::CH_HASH) begin
          m = stl_pkg::MODE_COMMENT;
        end else if (is_alpha(c)) begin
          m = stl_pkg::MODE_NAME;
          r[n] = mk_text(c);
          n = n + 2'd1;
        end else if (is_digit(c)) begin
          m = stl_pkg::MODE_INT;
          a = {60'd0, c[3:0]};
          r[n] = mk_text(c);
          n = n + 2'd1;
        end else begin
          case (c)
            stl_pkg::CH_DOT: begin
              m = stl_pkg::MODE_SYMBOL;
            end
            stl_pkg::CH_QUOTE: begin
              m = stl_pkg::MODE_STRING;
              e = 1'b0;
            end
            stl_pkg::CH_LBRACE: begin
              r[n] = mk_done(stl_pkg::KIND_LBRACE, '0);
              n = n + 2'd1;
            end
            stl_pkg::CH_RBRACE: begin
              r[n] = mk_done(stl_pkg::KIND_RBRACE, '0);
              n = n + 2'd1;
            end
            stl_pkg::CH_LPAREN: begin
              r[n] = mk_done(stl_pkg::KIND_LPAREN, '0);
              n = n + 2'd1;
            end
            stl_pkg::CH_RPAREN: begin
              r[n] = mk_done(stl_pkg::KIND_RPAREN, '0);
              n = n + 2'd1;
            end
            stl_pkg::CH_PLUS: begin
              r[n] = mk_done(stl_pkg::KIND_PLUS, '0);
              n = n + 2'd1;
            end
            stl_pkg::CH_MINUS: begin
              r[n] = mk_done(stl_pkg::KIND_MINUS, '0);
              n = n + 2'd1;
            end
            stl_pkg::CH_STAR: begin
              r[n] = mk_done(stl_pkg::KIND_STAR, '0);
              n = n + 2'd1;
            end
            stl_pkg::CH_SLASH: begin
              r[n] = mk_done(stl_pkg::KIND_SLASH, '0);
              n = n + 2'd1;
            end
            stl_pkg::CH_COMMA: begin
              r[n] = mk_done(stl_pkg::KIND_COMMA, '0);
              n = n + 2'd1;
            end
            stl_pkg::CH_RBRACK, stl_pkg::CH_SEMI: begin
              r[n] = mk_done(stl_pkg::KIND_CLOSING, '0);
              n = n + 2'd1;
            end
            default: begin
              r[n] = mk_done(stl_pkg::KIND_UNKNOWN, '0);
              n = n + 2'd1;
            end
          endcase
        end
      end
    end

    if (n != 2'd0) begin
      r[n - 2'd1].last_of_run = 1'b1;
    end

    step.res  = r;
    step.cnt  = n;
    step.mode = m;
    step.esc  = e;
    step.acc  = a;
  end

endmodule
